@@ sv/pidt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pidt_pkg
// Shared constants, register indexes, mode codes and stage types for the
// heater PID regulator.
// ----------------------------------------------------------------------------
package pidt_pkg;

    localparam int TEMP_W   = 14;
    localparam int ERR_W    = 15;
    localparam int PREV_W   = 16;
    localparam int DERIV_W  = 17;
    localparam int ACC_W    = 7;
    localparam int GAIN_W   = 16;
    localparam int BAND_W   = 13;
    localparam int DUTY_W   = 11;
    localparam int MODE_W   = 3;
    localparam int IDX_W    = 4;
    localparam int DATA_W   = 16;

    localparam int PROD_P_W = 32;
    localparam int PROD_D_W = 34;
    localparam int PROD_I_W = 24;
    localparam int SUM_W    = 35;

    localparam int DUTY_MIN       = 160;
    localparam int DUTY_MAX       = 1440;
    localparam int INTEGRAL_LIMIT = 48;

    // register indexes
    localparam logic [IDX_W-1:0] REG_SET_TEMP      = 4'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_P        = 4'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_I        = 4'd2;
    localparam logic [IDX_W-1:0] REG_GAIN_D        = 4'd3;
    localparam logic [IDX_W-1:0] REG_MAX_TEMP      = 4'd4;
    localparam logic [IDX_W-1:0] REG_MIN_TEMP      = 4'd5;
    localparam logic [IDX_W-1:0] REG_SEPARATE_BAND = 4'd6;
    localparam logic [IDX_W-1:0] REG_DEAD_BAND     = 4'd7;

    // result modes
    localparam logic [MODE_W-1:0] MODE_OVER  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UNDER = 3'd1;
    localparam logic [MODE_W-1:0] MODE_P     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PD    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PID   = 3'd4;

    // multiplier operands after the decision stage
    typedef struct packed {
        logic signed [ERR_W-1:0]   err_op;
        logic signed [DERIV_W-1:0] deriv_op;
        logic signed [ACC_W-1:0]   acc_op;
        logic [MODE_W-1:0]         mode;
    } t_terms;

    // products after the multiply stage
    typedef struct packed {
        logic signed [PROD_P_W-1:0] prod_p;
        logic signed [PROD_D_W-1:0] prod_d;
        logic signed [PROD_I_W-1:0] prod_i;
        logic [MODE_W-1:0]          mode;
    } t_prods;

endpackage
`default_nettype wire

@@ sv/pidt_duty_clamp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pidt_duty_clamp
// Sums the three control terms, rounds to 1/16 percent and clamps the duty.
// ----------------------------------------------------------------------------
module pidt_duty_clamp
    import pidt_pkg::*;
(
    input  wire t_prods             i_prods,
    output logic [DUTY_W-1:0]       o_duty
);

    logic signed [SUM_W-1:0] w_sum;
    logic [SUM_W:0]          w_round;
    logic [SUM_W-8:0]        w_q;

    always_comb begin
        w_sum = SUM_W'(i_prods.prod_p) + SUM_W'(i_prods.prod_d) + SUM_W'(i_prods.prod_i);
        // round to nearest, ties up; negative drive counts as zero
        w_round = {1'b0, w_sum} + (SUM_W+1)'(128);
        if (w_sum[SUM_W-1]) begin
            w_q = '0;
        end else begin
            w_q = w_round[SUM_W:8];
        end
        // max clamp first, min clamp last
        if (w_q > (SUM_W-7)'(DUTY_MAX)) begin
            w_q = (SUM_W-7)'(DUTY_MAX);
        end
        if (w_q < (SUM_W-7)'(DUTY_MIN)) begin
            w_q = (SUM_W-7)'(DUTY_MIN);
        end
        o_duty = w_q[DUTY_W-1:0];
    end

endmodule
`default_nettype wire

@@ sv/pid_temperature_regulator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pid_temperature_regulator
// Heater PID regulator with integral separation and a dead band.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one averaged temperature per control tick on the input channel
//   (i_in_valid / o_in_ready, i_measured_temp, 1/16 degree). Each input beat
//   yields exactly one output beat (o_out_valid / i_out_ready) carrying the
//   heater duty in 1/16 percent and the control mode.
//   Configuration registers are written over a separate valid/ready channel
//   (i_cfg_index, i_cfg_data); o_cfg_ready is always high, unknown indexes
//   are dropped. Write configuration only while the block is idle.
//   Throughput: one beat per cycle while the receiver does not stall. The
//   input is registered, then passes through three pipeline stages: decision
//   and state update, the three term multipliers, then sum, round and clamp.
//   Reset (synchronous, active low) loads register defaults, clears the
//   integral and the previous error, and empties the pipeline.
//   When the receiver stalls, the result holds in the output register and
//   each stage fills in turn; input ready drops only once all stages hold
//   an item.
// ----------------------------------------------------------------------------
module pid_temperature_regulator
    import pidt_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    // configuration
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire [IDX_W-1:0]          i_cfg_index,
    input  wire [DATA_W-1:0]         i_cfg_data,
    // input samples
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire signed [TEMP_W-1:0]  i_measured_temp,
    // results
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output logic [DUTY_W-1:0]        o_duty,
    output logic [MODE_W-1:0]        o_mode
);

    // configuration registers
    logic signed [TEMP_W-1:0] r_set_temp;
    logic [GAIN_W-1:0]        r_gain_p;
    logic [GAIN_W-1:0]        r_gain_i;
    logic [GAIN_W-1:0]        r_gain_d;
    logic signed [TEMP_W-1:0] r_max_temp;
    logic signed [TEMP_W-1:0] r_min_temp;
    logic [BAND_W-1:0]        r_separate_band;
    logic [BAND_W-1:0]        r_dead_band;

    // controller state
    logic signed [ACC_W-1:0]  r_accum_error;
    logic signed [PREV_W-1:0] r_previous_error;
    logic signed [ACC_W-1:0]  n_accum_error;
    logic signed [PREV_W-1:0] n_previous_error;

    // pipeline
    logic                     r_v0, r_v1, r_v2, r_out_valid;
    logic signed [TEMP_W-1:0] r_meas;
    t_terms                   r_terms;
    t_terms                   n_terms;
    t_prods                   r_prods;
    t_prods                   n_prods;
    logic [DUTY_W-1:0]        r_duty;
    logic [MODE_W-1:0]        r_mode;
    logic [DUTY_W-1:0]        w_duty;

    logic w_rdy0, w_rdy1, w_rdy2, w_rdy_out;

    // decision-stage signals
    logic signed [ERR_W-1:0]   w_err;
    logic signed [DERIV_W-1:0] w_deriv;
    logic signed [PREV_W-1:0]  w_acc_sum;
    logic                      w_over, w_under, w_neg, w_ponly, w_dead;

    assign o_cfg_ready = 1'b1;

    // Each stage takes a new beat when empty or when its contents move on.
    assign w_rdy_out = !r_out_valid || i_out_ready;
    assign w_rdy2    = !r_v2 || w_rdy_out;
    assign w_rdy1    = !r_v1 || w_rdy2;
    assign w_rdy0    = !r_v0 || w_rdy1;
    assign o_in_ready = w_rdy0;

    // ---------------------------------------------------------------------
    // Configuration writes
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_temp      <= 14'sd2960;
            r_gain_p        <= 16'd1280;
            r_gain_i        <= 16'd3840;
            r_gain_d        <= 16'd5120;
            r_max_temp      <= 14'sd3200;
            r_min_temp      <= 14'sd0;
            r_separate_band <= 13'd80;
            r_dead_band     <= 13'd8;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SET_TEMP:      r_set_temp      <= i_cfg_data[TEMP_W-1:0];
                REG_GAIN_P:        r_gain_p        <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I:        r_gain_i        <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D:        r_gain_d        <= i_cfg_data[GAIN_W-1:0];
                REG_MAX_TEMP:      r_max_temp      <= i_cfg_data[TEMP_W-1:0];
                REG_MIN_TEMP:      r_min_temp      <= i_cfg_data[TEMP_W-1:0];
                REG_SEPARATE_BAND: r_separate_band <= i_cfg_data[BAND_W-1:0];
                REG_DEAD_BAND:     r_dead_band     <= i_cfg_data[BAND_W-1:0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Decision stage: error, mode, new integral and previous error
    // ---------------------------------------------------------------------
    always_comb begin
        w_err   = {r_set_temp[TEMP_W-1], r_set_temp} - {r_meas[TEMP_W-1], r_meas};
        w_over  = r_meas > r_max_temp;
        w_under = r_meas < r_min_temp;
        w_neg   = w_err[ERR_W-1];
        w_ponly = w_err > $signed({2'b00, r_separate_band});
        w_dead  = w_err < $signed({2'b00, r_dead_band});
        w_deriv = {{2{w_err[ERR_W-1]}}, w_err}
                - {r_previous_error[PREV_W-1], r_previous_error};
        w_acc_sum = {{(PREV_W-ACC_W){r_accum_error[ACC_W-1]}}, r_accum_error}
                  + {w_err[ERR_W-1], w_err};

        n_accum_error    = r_accum_error;
        n_previous_error = {w_err[ERR_W-1], w_err};
        n_terms.err_op   = w_err;
        n_terms.deriv_op = w_deriv;
        n_terms.acc_op   = '0;
        n_terms.mode     = MODE_PID;

        if (w_over || w_under || w_neg) begin
            // cut off: clear state, zero drive
            n_accum_error    = '0;
            n_previous_error = '0;
            n_terms.err_op   = '0;
            n_terms.deriv_op = '0;
            n_terms.mode     = w_over ? MODE_OVER : MODE_UNDER;
        end else if (w_ponly) begin
            // far from target: proportional only, integral held
            n_terms.deriv_op = '0;
            n_terms.mode     = MODE_P;
        end else begin
            // accumulate and clamp the integral
            if (w_acc_sum > $signed(PREV_W'(INTEGRAL_LIMIT))) begin
                n_accum_error = ACC_W'(INTEGRAL_LIMIT);
            end else if (w_acc_sum < -$signed(PREV_W'(INTEGRAL_LIMIT))) begin
                n_accum_error = -$signed(ACC_W'(INTEGRAL_LIMIT));
            end else begin
                n_accum_error = w_acc_sum[ACC_W-1:0];
            end
            if (w_dead) begin
                n_terms.mode = MODE_PD;
            end else begin
                n_terms.acc_op = n_accum_error;
                n_terms.mode   = MODE_PID;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Multiply stage
    // ---------------------------------------------------------------------
    always_comb begin
        n_prods.prod_p = $signed({{(PROD_P_W-GAIN_W){1'b0}}, r_gain_p})
                       * $signed({{(PROD_P_W-ERR_W){r_terms.err_op[ERR_W-1]}},
                                  r_terms.err_op});
        n_prods.prod_d = $signed({{(PROD_D_W-GAIN_W){1'b0}}, r_gain_d})
                       * $signed({{(PROD_D_W-DERIV_W){r_terms.deriv_op[DERIV_W-1]}},
                                  r_terms.deriv_op});
        n_prods.prod_i = $signed({{(PROD_I_W-GAIN_W){1'b0}}, r_gain_i})
                       * $signed({{(PROD_I_W-ACC_W){r_terms.acc_op[ACC_W-1]}},
                                  r_terms.acc_op});
        n_prods.mode   = r_terms.mode;
    end

    pidt_duty_clamp u_duty_clamp (
        .i_prods (r_prods),
        .o_duty  (w_duty)
    );

    // ---------------------------------------------------------------------
    // Pipeline valids and controller state
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0             <= 1'b0;
            r_v1             <= 1'b0;
            r_v2             <= 1'b0;
            r_out_valid      <= 1'b0;
            r_accum_error    <= '0;
            r_previous_error <= '0;
        end else begin
            if (w_rdy0)    r_v0        <= i_in_valid;
            if (w_rdy1)    r_v1        <= r_v0;
            if (w_rdy2)    r_v2        <= r_v1;
            if (w_rdy_out) r_out_valid <= r_v2;
            // advance state exactly once per beat, as it leaves stage 0
            if (w_rdy1 && r_v0) begin
                r_accum_error    <= n_accum_error;
                r_previous_error <= n_previous_error;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_rdy0 && i_in_valid) r_meas  <= i_measured_temp;
        if (w_rdy1 && r_v0)       r_terms <= n_terms;
        if (w_rdy2 && r_v1)       r_prods <= n_prods;
        if (w_rdy_out && r_v2) begin
            r_duty <= w_duty;
            r_mode <= r_prods.mode;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_duty      = r_duty;
    assign o_mode      = r_mode;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_duty >= DUTY_W'(DUTY_MIN)) && (o_duty <= DUTY_W'(DUTY_MAX)))
        else $error("duty outside clamp range");

    a_cutoff_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_mode == MODE_OVER || o_mode == MODE_UNDER)
        |-> o_duty == DUTY_W'(DUTY_MIN))
        else $error("cut-off mode without minimum duty");

    a_accum_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_accum_error <= $signed(ACC_W'(INTEGRAL_LIMIT)))
        && (r_accum_error >= -$signed(ACC_W'(INTEGRAL_LIMIT))))
        else $error("integral beyond limit");

    a_cutoff_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rdy1 && r_v0 && (w_over || w_under || w_neg))
        |=> (r_accum_error == '0) && (r_previous_error == '0))
        else $error("cut-off did not clear state");

endmodule
`default_nettype wire
